// ===== rtl/core/look_at_view_matrix_top_assert.svh =====
// Assertion macros for the look-at view matrix block.
// Depends on nothing; the checker takes it in with an include line.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk and held off during reset.
`define LAVM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and held off during reset.
`define LAVM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lavm_pkg.sv =====
// Shared types, constants and helper functions of the look-at view matrix block.
// Depends on nothing; used by lavm_unitize, the top level and the checker.
package lavm_pkg;

    typedef logic signed [31:0] t_q32;

    // Row codes of the result beats.
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    // Normalised mantissa width and square root steps of the unit-vector pipeline.
    localparam int MANT_W     = 31;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_REM_W = SQRT_STEPS + 3;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // Latency in cycles of lavm_unitize for a given input width.
    function automatic int unit_lat(input int in_w, input int frac);
        int mw;
        mw = (in_w > 32) ? in_w : 32;
        return $clog2(mw) + frac + SQRT_STEPS + 6;
    endfunction

    // Drops frac fraction bits, rounding half away from zero.
    function automatic logic signed [63:0] round_q(input logic signed [63:0] v,
                                                   input int frac);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? (64'd0 - v) : v;
        res = (mag + (64'd1 << (frac - 1))) >> frac;
        return v[63] ? (64'd0 - res) : res;
    endfunction

    // Saturates to the signed 32-bit range.
    function automatic t_q32 sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end
        return r[31:0];
    endfunction

endpackage

// ===== rtl/core/look_at_view_matrix_top.sv =====
// Top level of the look-at view matrix block: input stage, two unit-vector
// pipelines, cross and dot product stages and the three-row result serialiser.
// Depends on lavm_pkg and lavm_unitize.
//
//   Channel  Direction  Handshake                   Beat
//   input    in         i_in_valid / o_in_stall     eye, target, up hint
//   output   out        o_out_valid / i_out_stall   one matrix row
//
// Each item gives three output beats: right, up and negated forward rows.
// The sustained rate is bounded by those three beats on the single result
// port; the pipeline itself takes an item every cycle unless it is frozen.
// The first row is offered after the item has passed the input stage, both
// unit-vector pipelines, the cross product stages and X1 to X6, most of the
// delay in the unit-vector square roots and divisions. Reset is synchronous
// and clears only valid bits and the serialiser. The whole pipeline freezes
// at once when its last stage holds an item the serialiser cannot take, and the input then stalls.
module look_at_view_matrix_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_hint_x,
    input  logic signed [31:0] i_up_hint_y,
    input  logic signed [31:0] i_up_hint_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_translation,
    output logic               o_degenerate,
    output logic               o_last_row
);

    // Unit vectors carry FRAC_BITS + 2 bits, since one unit itself can occur.
    localparam int UNW = FRAC_BITS + 2;
    localparam int PW  = 2 * FRAC_BITS + 4;   // product of two unit components
    localparam int CW  = 2 * FRAC_BITS + 5;   // exact cross product component
    localparam int UW  = FRAC_BITS + 5;       // rounded true-up component
    localparam int DPW = FRAC_BITS + 34;      // unit component times eye
    localparam int DW  = FRAC_BITS + 36;      // dot product with eye
    localparam int EPW = FRAC_BITS + 37;      // true-up component times eye
    localparam int EDW = FRAC_BITS + 39;      // true-up dot eye
    localparam int L1  = lavm_pkg::unit_lat(33, FRAC_BITS);
    localparam int L2  = lavm_pkg::unit_lat(CW, FRAC_BITS);
    localparam logic signed [CW-1:0] ONE_Q =
        {{(CW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic w_en;
    logic w_out_fire;
    logic w_ser_free;
    logic w_load;

    // Input stage: eye, direction to target and sign-extended up hint.
    logic                r_t0_v;
    lavm_pkg::t_q32      r_eye [3];
    logic signed [32:0]  r_d   [3];
    logic signed [32:0]  r_up  [3];

    // Side data alongside the first unit-vector pipeline.
    logic                r_d1_v   [0:L1-1];
    lavm_pkg::t_q32      r_d1_eye [0:L1-1][3];
    logic signed [UNW-1:0] w_f  [3];
    logic signed [UNW-1:0] w_uh [3];

    // First cross product.
    logic                r_c1_v;
    logic signed [PW-1:0]  r_c1_pp [6];
    logic signed [UNW-1:0] r_c1_f  [3];
    lavm_pkg::t_q32        r_c1_eye [3];
    logic                r_c2_v;
    logic signed [CW-1:0]  r_c2_c  [3];
    logic signed [UNW-1:0] r_c2_f  [3];
    lavm_pkg::t_q32        r_c2_eye [3];
    logic                  w_deg;

    // Side data alongside the second unit-vector pipeline.
    logic                  r_d2_v   [0:L2-1];
    logic                  r_d2_deg [0:L2-1];
    logic signed [UNW-1:0] r_d2_f   [0:L2-1][3];
    lavm_pkg::t_q32        r_d2_eye [0:L2-1][3];
    logic signed [UNW-1:0] w_s [3];

    // Back-end stages X1 to X6.
    logic                  r_xv   [1:6];
    logic                  r_xdeg [1:6];
    logic signed [UNW-1:0] r_xs   [1:6][3];
    logic signed [UNW-1:0] r_xf   [1:6][3];
    lavm_pkg::t_q32        r_xeye [1:3][3];
    logic signed [UW-1:0]  r_xu   [3:6][3];
    lavm_pkg::t_q32        r_xt0  [3:6];
    lavm_pkg::t_q32        r_xt2  [3:6];
    logic signed [PW-1:0]  r_x1_pp [6];
    logic signed [DPW-1:0] r_x1_sp [3];
    logic signed [DPW-1:0] r_x1_fp [3];
    logic signed [CW-1:0]  r_x2_uc [3];
    logic signed [DW-1:0]  r_x2_sd;
    logic signed [DW-1:0]  r_x2_fd;
    logic signed [EPW-1:0] r_x4_up [3];
    logic signed [EDW-1:0] r_x5_ud;
    lavm_pkg::t_q32        r_x6_t1;

    // Result serialiser: one item's three rows, sent one beat at a time.
    logic                 r_busy;
    logic [1:0]           r_row;
    lavm_pkg::t_q32       r_o_rows [3][3];
    lavm_pkg::t_q32       r_o_tr   [3];
    logic                 r_o_deg;

    // The pipeline advances unless its last stage holds an item that the
    // serialiser cannot take this cycle.
    assign w_out_fire = r_busy && !i_out_stall;
    assign w_ser_free = !r_busy || (w_out_fire && (r_row == lavm_pkg::ROW_FWD));
    assign w_en       = !r_xv[6] || w_ser_free;
    assign w_load     = w_en && r_xv[6];
    assign o_in_stall = !w_en;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            for (int k = 0; k < L1; k++) begin
                r_d1_v[k] <= 1'b0;
            end
            for (int k = 0; k < L2; k++) begin
                r_d2_v[k] <= 1'b0;
            end
            for (int k = 1; k <= 6; k++) begin
                r_xv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_t0_v    <= i_in_valid;
            r_d1_v[0] <= r_t0_v;
            for (int k = 1; k < L1; k++) begin
                r_d1_v[k] <= r_d1_v[k-1];
            end
            r_c1_v    <= r_d1_v[L1-1];
            r_c2_v    <= r_c1_v;
            r_d2_v[0] <= r_c2_v;
            for (int k = 1; k < L2; k++) begin
                r_d2_v[k] <= r_d2_v[k-1];
            end
            r_xv[1] <= r_d2_v[L2-1];
            for (int k = 2; k <= 6; k++) begin
                r_xv[k] <= r_xv[k-1];
            end
        end
    end

    // Input stage and the side data of the first unit-vector pipeline.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_eye[0] <= i_eye_x;
            r_eye[1] <= i_eye_y;
            r_eye[2] <= i_eye_z;
            r_d[0]   <= 33'(i_target_x) - 33'(i_eye_x);
            r_d[1]   <= 33'(i_target_y) - 33'(i_eye_y);
            r_d[2]   <= 33'(i_target_z) - 33'(i_eye_z);
            r_up[0]  <= 33'(i_up_hint_x);
            r_up[1]  <= 33'(i_up_hint_y);
            r_up[2]  <= 33'(i_up_hint_z);
            r_d1_eye[0] <= r_eye;
            for (int k = 1; k < L1; k++) begin
                r_d1_eye[k] <= r_d1_eye[k-1];
            end
        end
    end

    lavm_unitize #(
        .IN_W      (33),
        .FRAC_BITS (FRAC_BITS)
    ) u_unit_fwd (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_d),
        .o_unit (w_f)
    );

    lavm_unitize #(
        .IN_W      (33),
        .FRAC_BITS (FRAC_BITS)
    ) u_unit_up (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_up),
        .o_unit (w_uh)
    );

    // Forward crossed with the unit up hint, formed exactly.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_pp[0] <= PW'(w_f[1]) * PW'(w_uh[2]);
            r_c1_pp[1] <= PW'(w_f[2]) * PW'(w_uh[1]);
            r_c1_pp[2] <= PW'(w_f[2]) * PW'(w_uh[0]);
            r_c1_pp[3] <= PW'(w_f[0]) * PW'(w_uh[2]);
            r_c1_pp[4] <= PW'(w_f[0]) * PW'(w_uh[1]);
            r_c1_pp[5] <= PW'(w_f[1]) * PW'(w_uh[0]);
            r_c1_f     <= w_f;
            r_c1_eye   <= r_d1_eye[L1-1];
            for (int i = 0; i < 3; i++) begin
                r_c2_c[i] <= CW'(r_c1_pp[2*i]) - CW'(r_c1_pp[2*i+1]);
            end
            r_c2_f   <= r_c1_f;
            r_c2_eye <= r_c1_eye;
        end
    end

    // Forward and up count as collinear when every component of the exact cross
    // product lies strictly within ONE_Q of zero, which at the product's 2 * FRAC_BITS scale is 2^-FRAC_BITS.
    always_comb begin
        w_deg = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if ((r_c2_c[i] >= ONE_Q) || (r_c2_c[i] <= -ONE_Q)) begin
                w_deg = 1'b0;
            end
        end
    end

    lavm_unitize #(
        .IN_W      (CW),
        .FRAC_BITS (FRAC_BITS)
    ) u_unit_right (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_c2_c),
        .o_unit (w_s)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_f[0]   <= r_c2_f;
            r_d2_eye[0] <= r_c2_eye;
            r_d2_deg[0] <= w_deg;
            for (int k = 1; k < L2; k++) begin
                r_d2_f[k]   <= r_d2_f[k-1];
                r_d2_eye[k] <= r_d2_eye[k-1];
                r_d2_deg[k] <= r_d2_deg[k-1];
            end
        end
    end

    // Back end: true up vector and the three translations.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // X1: products of right with forward and of right and forward with eye.
            r_x1_pp[0] <= PW'(w_s[1]) * PW'(r_d2_f[L2-1][2]);
            r_x1_pp[1] <= PW'(w_s[2]) * PW'(r_d2_f[L2-1][1]);
            r_x1_pp[2] <= PW'(w_s[2]) * PW'(r_d2_f[L2-1][0]);
            r_x1_pp[3] <= PW'(w_s[0]) * PW'(r_d2_f[L2-1][2]);
            r_x1_pp[4] <= PW'(w_s[0]) * PW'(r_d2_f[L2-1][1]);
            r_x1_pp[5] <= PW'(w_s[1]) * PW'(r_d2_f[L2-1][0]);
            for (int i = 0; i < 3; i++) begin
                r_x1_sp[i] <= DPW'(w_s[i]) * DPW'(r_d2_eye[L2-1][i]);
                r_x1_fp[i] <= DPW'(r_d2_f[L2-1][i]) * DPW'(r_d2_eye[L2-1][i]);
            end
            r_xs[1]   <= w_s;
            r_xf[1]   <= r_d2_f[L2-1];
            r_xeye[1] <= r_d2_eye[L2-1];
            r_xdeg[1] <= r_d2_deg[L2-1];

            // X2: sums.
            for (int i = 0; i < 3; i++) begin
                r_x2_uc[i] <= CW'(r_x1_pp[2*i]) - CW'(r_x1_pp[2*i+1]);
            end
            r_x2_sd <= DW'(r_x1_sp[0]) + DW'(r_x1_sp[1]) + DW'(r_x1_sp[2]);
            r_x2_fd <= DW'(r_x1_fp[0]) + DW'(r_x1_fp[1]) + DW'(r_x1_fp[2]);

            // X3: rounding to FRAC_BITS and saturation of the outer translations.
            for (int i = 0; i < 3; i++) begin
                r_xu[3][i] <= UW'(lavm_pkg::round_q(64'(r_x2_uc[i]), FRAC_BITS));
            end
            r_xt0[3] <= lavm_pkg::sat32(-lavm_pkg::round_q(64'(r_x2_sd), FRAC_BITS));
            r_xt2[3] <= lavm_pkg::sat32(lavm_pkg::round_q(64'(r_x2_fd), FRAC_BITS));

            // X4 to X6: true up dotted with eye.
            for (int i = 0; i < 3; i++) begin
                r_x4_up[i] <= EPW'(r_xu[3][i]) * EPW'(r_xeye[3][i]);
            end
            r_x5_ud <= EDW'(r_x4_up[0]) + EDW'(r_x4_up[1]) + EDW'(r_x4_up[2]);
            r_x6_t1 <= lavm_pkg::sat32(-lavm_pkg::round_q(64'(r_x5_ud), FRAC_BITS));

            for (int k = 2; k <= 6; k++) begin
                r_xs[k]   <= r_xs[k-1];
                r_xf[k]   <= r_xf[k-1];
                r_xdeg[k] <= r_xdeg[k-1];
            end
            for (int k = 2; k <= 3; k++) begin
                r_xeye[k] <= r_xeye[k-1];
            end
            for (int k = 4; k <= 6; k++) begin
                r_xu[k]  <= r_xu[k-1];
                r_xt0[k] <= r_xt0[k-1];
                r_xt2[k] <= r_xt2[k-1];
            end
        end
    end

    // Serialiser payload, captured whole when an item leaves the pipeline.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < 3; i++) begin
                r_o_rows[0][i] <= 32'(r_xs[6][i]);
                r_o_rows[1][i] <= 32'(r_xu[6][i]);
                r_o_rows[2][i] <= -32'(r_xf[6][i]);
            end
            r_o_tr[0] <= r_xt0[6];
            r_o_tr[1] <= r_x6_t1;
            r_o_tr[2] <= r_xt2[6];
            r_o_deg   <= r_xdeg[6];
        end
    end

    // Serialiser control: a new item may load in the cycle its predecessor's
    // last row is taken, so rows leave back to back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= lavm_pkg::ROW_RIGHT;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_row  <= lavm_pkg::ROW_RIGHT;
        end else if (w_out_fire) begin
            case (r_row)
                lavm_pkg::ROW_RIGHT: begin
                    r_row <= lavm_pkg::ROW_UP;
                end
                lavm_pkg::ROW_UP: begin
                    r_row <= lavm_pkg::ROW_FWD;
                end
                default: begin
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        case (r_row)
            lavm_pkg::ROW_RIGHT: begin
                o_col0        = r_o_rows[0][0];
                o_col1        = r_o_rows[0][1];
                o_col2        = r_o_rows[0][2];
                o_translation = r_o_tr[0];
            end
            lavm_pkg::ROW_UP: begin
                o_col0        = r_o_rows[1][0];
                o_col1        = r_o_rows[1][1];
                o_col2        = r_o_rows[1][2];
                o_translation = r_o_tr[1];
            end
            default: begin
                o_col0        = r_o_rows[2][0];
                o_col1        = r_o_rows[2][1];
                o_col2        = r_o_rows[2][2];
                o_translation = r_o_tr[2];
            end
        endcase
    end

    assign o_out_valid  = r_busy;
    assign o_row_index  = r_row;
    assign o_degenerate = r_o_deg;
    assign o_last_row   = (r_row == lavm_pkg::ROW_FWD);

endmodule

// ===== rtl/core/lavm_unitize.sv =====
// Pipelined unit-vector unit: normalising shift, squares, square root, division.
// Depends on lavm_pkg.
module lavm_unitize #(
    parameter int IN_W      = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [IN_W-1:0]   i_vec  [3],
    output logic signed [FRAC_BITS+1:0] o_unit [3]
);

    localparam int MW   = (IN_W > 32) ? IN_W : 32;
    localparam int LZ   = $clog2(MW);
    localparam int MANT = lavm_pkg::MANT_W;
    localparam int SQN  = lavm_pkg::SQRT_STEPS;
    localparam int RW   = lavm_pkg::SQRT_REM_W;
    localparam int OW   = FRAC_BITS + 2;
    localparam int NW   = FRAC_BITS + 32;
    localparam int QW   = FRAC_BITS + 1;

    // Magnitude and normalising shift stages.
    logic [IN_W-1:0] w_mag [3];
    logic [MW-1:0]   r_sh  [0:LZ][3];
    logic            r_shn [0:LZ][3];
    logic            r_shz [0:LZ];

    // Square stage.
    logic [MANT-1:0]   r_m31 [3];
    logic [2*MANT-1:0] r_sq  [3];
    logic              r_sqn [3];
    logic              r_sqz;

    // Square root stages.
    logic [RW-1:0]    r_rem  [0:SQN];
    logic [SQN-1:0]   r_root [0:SQN];
    logic [2*SQN-1:0] r_n2   [0:SQN];
    logic [MANT-1:0]  r_qm   [0:SQN][3];
    logic             r_qn   [0:SQN][3];
    logic             r_qz   [0:SQN];

    // Division stages.
    logic [NW-1:0]  w_num [3];
    logic [NW-1:0]  r_num [0:QW][3];
    logic [SQN-1:0] r_dr  [0:QW][3];
    logic [QW-1:0]  r_dq  [0:QW][3];
    logic [SQN-1:0] r_dn  [0:QW];
    logic           r_dneg [0:QW][3];
    logic           r_dz  [0:QW];

    logic signed [OW-1:0] r_out [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_vec[i][IN_W-1] ? IN_W'(-i_vec[i]) : IN_W'(i_vec[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sh[0][i]  <= MW'(w_mag[i]);
                r_shn[0][i] <= i_vec[i][IN_W-1];
            end
            r_shz[0] <= (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);
        end
    end

    // Each stage shifts all three magnitudes left by a power of two while the
    // top bits of their union are clear, so the largest ends with its MSB on top.
    for (genvar k = 0; k < LZ; k++) begin : g_norm
        localparam int SH = 1 << (LZ - 1 - k);
        logic [MW-1:0] w_or;
        assign w_or = r_sh[k][0] | r_sh[k][1] | r_sh[k][2];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sh[k+1][i]  <= (w_or[MW-1 -: SH] == '0) ? (r_sh[k][i] << SH)
                                                              : r_sh[k][i];
                    r_shn[k+1][i] <= r_shn[k][i];
                end
                r_shz[k+1] <= r_shz[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m31[i] <= r_sh[LZ][i][MW-1 -: MANT];
                r_sq[i]  <= (2*MANT)'(r_sh[LZ][i][MW-1 -: MANT])
                          * (2*MANT)'(r_sh[LZ][i][MW-1 -: MANT]);
                r_sqn[i] <= r_shn[LZ][i];
            end
            r_sqz <= r_shz[LZ];
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_n2[0]   <= (2*SQN)'(r_sq[0]) + (2*SQN)'(r_sq[1]) + (2*SQN)'(r_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r_qm[0][i] <= r_m31[i];
                r_qn[0][i] <= r_sqn[i];
            end
            r_qz[0] <= r_sqz;
        end
    end

    // Digit-by-digit square root, two radicand bits per stage.
    for (genvar j = 0; j < SQN; j++) begin : g_sqrt
        logic [RW-1:0] w_rs;
        logic [RW-1:0] w_trial;
        logic          w_ge;
        assign w_rs    = {r_rem[j][RW-3:0], r_n2[j][2*SQN-1-2*j -: 2]};
        assign w_trial = {1'b0, r_root[j], 2'b01};
        assign w_ge    = (w_rs >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_ge ? (w_rs - w_trial) : w_rs;
                r_root[j+1] <= {r_root[j][SQN-2:0], w_ge};
                r_n2[j+1]   <= r_n2[j];
                r_qm[j+1]   <= r_qm[j];
                r_qn[j+1]   <= r_qn[j];
                r_qz[j+1]   <= r_qz[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = NW'({r_qm[SQN][i], {FRAC_BITS{1'b0}}}) + NW'(r_root[SQN] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[0][i]  <= w_num[i];
                r_dr[0][i]   <= SQN'(w_num[i] >> (FRAC_BITS + 1));
                r_dq[0][i]   <= '0;
                r_dneg[0][i] <= r_qn[SQN][i];
            end
            r_dn[0] <= r_root[SQN];
            r_dz[0] <= r_qz[SQN];
        end
    end

    // Restoring division, one quotient bit per stage; the quotient never
    // exceeds one unit, so FRAC_BITS + 1 bits suffice.
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [SQN:0] w_rs [3];
        logic         w_ge [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_rs[i] = {r_dr[k][i], r_num[k][i][FRAC_BITS-k]};
                w_ge[i] = (w_rs[i] >= {1'b0, r_dn[k]});
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dr[k+1][i]   <= w_ge[i] ? SQN'(w_rs[i] - {1'b0, r_dn[k]})
                                              : SQN'(w_rs[i]);
                    r_dq[k+1][i]   <= {r_dq[k][i][QW-2:0], w_ge[i]};
                    r_num[k+1][i]  <= r_num[k][i];
                    r_dneg[k+1][i] <= r_dneg[k][i];
                end
                r_dn[k+1] <= r_dn[k];
                r_dz[k+1] <= r_dz[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dz[QW]) begin
                    r_out[i] <= '0;
                end else if (r_dneg[QW][i]) begin
                    r_out[i] <= -OW'(r_dq[QW][i]);
                end else begin
                    r_out[i] <= OW'(r_dq[QW][i]);
                end
            end
        end
    end

    assign o_unit = r_out;

endmodule

// ===== rtl/core/lavm_checker.sv =====
// Port-level checker for the look-at view matrix block, bound to the top level.
// Depends on lavm_pkg and look_at_view_matrix_top_assert.svh.
`include "look_at_view_matrix_top_assert.svh"

module lavm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_row_index,
    input logic signed [31:0] o_col0,
    input logic               o_degenerate,
    input logic               o_last_row
);

    // A held beat keeps its row and data.
    `LAVM_ASSERT_NEXT(a_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_row_index) && $stable(o_col0), "stalled beat changed")

    // Rows of one item follow each other without a gap.
    `LAVM_ASSERT_NEXT(a_right_up, o_out_valid && !i_out_stall && (o_row_index == lavm_pkg::ROW_RIGHT), o_out_valid && (o_row_index == lavm_pkg::ROW_UP), "up row did not follow right row")

    `LAVM_ASSERT_NEXT(a_up_fwd, o_out_valid && !i_out_stall && (o_row_index == lavm_pkg::ROW_UP), o_out_valid && (o_row_index == lavm_pkg::ROW_FWD), "forward row did not follow up row")

    // The degenerate flag is the same on all rows of an item.
    `LAVM_ASSERT_NEXT(a_deg_same, o_out_valid && !i_out_stall && !o_last_row, o_degenerate == $past(o_degenerate), "degenerate flag changed within an item")

    // The input side only stalls behind a pending result beat.
    `LAVM_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid, "input stalled with no result pending")

endmodule

bind look_at_view_matrix_top lavm_checker u_lavm_checker (.*);
